[rtl/grmt_pkg.sv]
// ----------------------------------------------------------------------------
// grmt_pkg: shared types and constants for the grid range-maximum tree
// Item types, default grid size and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package grmt_pkg;

  localparam int unsigned GridRowsDef = 64;
  localparam int unsigned GridColsDef = 64;

  // Width that holds any index computation: up to 2 * 4096 plus one.
  localparam int unsigned IdxW = 14;

  localparam logic OpAssign = 1'b0;
  localparam logic OpQuery  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [5:0]         row;
    logic [5:0]         column;
    logic signed [31:0] value;
    logic [5:0]         row_low;
    logic [5:0]         row_high;
    logic [5:0]         col_low;
    logic [5:0]         col_high;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] max_value;
    logic               empty_res;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_U_LEAF,
    ST_U_RDA,
    ST_U_RDB,
    ST_U_WR,
    ST_Q_OLO,
    ST_Q_OHI,
    ST_Q_OSH,
    ST_Q_ILO,
    ST_Q_IHI,
    ST_Q_ISH,
    ST_Q_ACC,
    ST_Q_DONE
  } grmt_state_e;

endpackage

`default_nettype wire

[rtl/grmt_core.sv]
// ----------------------------------------------------------------------------
// grmt_core: tree store and access sequencer
// Holds the two-level segment tree in one synchronous memory and walks it
// for cell assignments (read, max, write back) and rectangle queries.
// ----------------------------------------------------------------------------
`default_nettype none

module grmt_core
  import grmt_pkg::*;
#(
  parameter int unsigned GRID_ROWS = GridRowsDef,
  parameter int unsigned GRID_COLS = GridColsDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           res_valid_o,
  input  wire logic      res_ready_i,
  output out_item_t      res_o
);

  localparam int unsigned RW = $clog2(2 * GRID_ROWS);
  localparam int unsigned CW = $clog2(2 * GRID_COLS);
  localparam int unsigned AW = RW + CW;

  grmt_state_e state_q, state_d;

  logic [31:0]   store_q [2**AW];
  logic [31:0]   rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata;

  logic [AW-1:0] clr_q, clr_d;
  logic [RW-1:0] r_q, r_d, cur_q, cur_d;
  logic [CW-1:0] c_q, c_d, cleaf_q, cleaf_d;
  logic          rowmode_q, rowmode_d;
  logic signed [31:0] tmp_q, tmp_d, best_q, best_d;
  logic          empty_q, empty_d;
  logic [RW:0]   lo_q, lo_d, hi_q, hi_d;
  logic [CW:0]   clo_q, clo_d, chi_q, chi_d, clo0_q, clo0_d, chi0_q, chi0_d;
  logic          ret_hi_q, ret_hi_d, acc_sh_q, acc_sh_d;

  // Decoded input item.
  logic [IdxW-1:0] row_sat, col_sat, leaf_r, leaf_c;
  logic [IdxW-1:0] rl, rh, cl, ch, rh_clip, ch_clip, lo0, hi0, clo0, chi0;
  logic            q_empty;
  logic signed [31:0] rd_s, wmax;

  always_comb begin
    row_sat = (IdxW'(in_item_i.row) >= IdxW'(GRID_ROWS)) ? IdxW'(GRID_ROWS - 1)
                                                         : IdxW'(in_item_i.row);
    col_sat = (IdxW'(in_item_i.column) >= IdxW'(GRID_COLS)) ? IdxW'(GRID_COLS - 1)
                                                            : IdxW'(in_item_i.column);
    leaf_r  = row_sat + IdxW'(GRID_ROWS);
    leaf_c  = col_sat + IdxW'(GRID_COLS);
    rl      = IdxW'(in_item_i.row_low);
    rh      = IdxW'(in_item_i.row_high);
    cl      = IdxW'(in_item_i.col_low);
    ch      = IdxW'(in_item_i.col_high);
    q_empty = (rl > rh) || (cl > ch) || (rl >= IdxW'(GRID_ROWS)) ||
              (cl >= IdxW'(GRID_COLS));
    rh_clip = (rh >= IdxW'(GRID_ROWS)) ? IdxW'(GRID_ROWS - 1) : rh;
    ch_clip = (ch >= IdxW'(GRID_COLS)) ? IdxW'(GRID_COLS - 1) : ch;
    lo0     = rl + IdxW'(GRID_ROWS);
    hi0     = rh_clip + IdxW'(GRID_ROWS + 1);
    clo0    = cl + IdxW'(GRID_COLS);
    chi0    = ch_clip + IdxW'(GRID_COLS + 1);
    rd_s    = $signed(rdata_q);
    wmax    = (tmp_q > rd_s) ? tmp_q : rd_s;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (&clr_q) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.operation == OpAssign) state_d = ST_U_LEAF;
          else if (q_empty)                    state_d = ST_Q_DONE;
          else                                 state_d = ST_Q_OLO;
        end
      end
      ST_U_LEAF: state_d = ST_U_RDA;
      ST_U_RDA:  state_d = ST_U_RDB;
      ST_U_RDB:  state_d = ST_U_WR;
      ST_U_WR: begin
        if (c_q != CW'(1) || r_q != RW'(1)) state_d = ST_U_RDA;
        else                                state_d = ST_IDLE;
      end
      ST_Q_OLO: begin
        if (lo_q >= hi_q) state_d = ST_Q_DONE;
        else if (lo_q[0]) state_d = ST_Q_ILO;
        else              state_d = ST_Q_OHI;
      end
      ST_Q_OHI:  state_d = hi_q[0] ? ST_Q_ILO : ST_Q_OSH;
      ST_Q_OSH:  state_d = ST_Q_OLO;
      ST_Q_ILO: begin
        if (clo_q >= chi_q) state_d = ret_hi_q ? ST_Q_OSH : ST_Q_OHI;
        else if (clo_q[0])  state_d = ST_Q_ACC;
        else                state_d = ST_Q_IHI;
      end
      ST_Q_IHI:  state_d = chi_q[0] ? ST_Q_ACC : ST_Q_ISH;
      ST_Q_ISH:  state_d = ST_Q_ILO;
      ST_Q_ACC:  state_d = acc_sh_q ? ST_Q_ISH : ST_Q_IHI;
      ST_Q_DONE: if (res_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    clr_d     = clr_q;
    r_d       = r_q;
    c_d       = c_q;
    cleaf_d   = cleaf_q;
    cur_d     = cur_q;
    rowmode_d = rowmode_q;
    tmp_d     = tmp_q;
    best_d    = best_q;
    empty_d   = empty_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    clo_d     = clo_q;
    chi_d     = chi_q;
    clo0_d    = clo0_q;
    chi0_d    = chi0_q;
    ret_hi_d  = ret_hi_q;
    acc_sh_d  = acc_sh_q;
    we        = 1'b0;
    waddr     = {r_q, c_q};
    wdata     = wmax;
    raddr     = {r_q, c_q};
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AW'(1);
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        r_d      = leaf_r[RW-1:0];
        c_d      = leaf_c[CW-1:0];
        cleaf_d  = leaf_c[CW-1:0];
        tmp_d    = in_item_i.value;
        lo_d     = lo0[RW:0];
        hi_d     = hi0[RW:0];
        clo0_d   = clo0[CW:0];
        chi0_d   = chi0[CW:0];
        best_d   = q_empty ? 32'sd0 : {1'b1, 31'd0};
        empty_d  = q_empty;
      end
      ST_U_LEAF: begin
        we        = 1'b1;
        wdata     = tmp_q;
        c_d       = c_q >> 1;
        rowmode_d = 1'b0;
      end
      ST_U_RDA: begin
        // In a row's first node the children are the two child rows.
        raddr = rowmode_q ? {r_q[RW-2:0], 1'b0, c_q} : {r_q, c_q[CW-2:0], 1'b0};
      end
      ST_U_RDB: begin
        raddr = rowmode_q ? {r_q[RW-2:0], 1'b1, c_q} : {r_q, c_q[CW-2:0], 1'b1};
        tmp_d = rd_s;
      end
      ST_U_WR: begin
        we = 1'b1;
        if (c_q != CW'(1)) begin
          c_d       = c_q >> 1;
          rowmode_d = 1'b0;
        end else begin
          r_d       = r_q >> 1;
          c_d       = cleaf_q;
          rowmode_d = 1'b1;
        end
      end
      ST_Q_OLO: begin
        if (lo_q < hi_q && lo_q[0]) begin
          cur_d    = lo_q[RW-1:0];
          lo_d     = lo_q + (RW+1)'(1);
          clo_d    = clo0_q;
          chi_d    = chi0_q;
          ret_hi_d = 1'b0;
        end
      end
      ST_Q_OHI: begin
        if (hi_q[0]) begin
          hi_d     = hi_q - (RW+1)'(1);
          cur_d    = hi_d[RW-1:0];
          clo_d    = clo0_q;
          chi_d    = chi0_q;
          ret_hi_d = 1'b1;
        end
      end
      ST_Q_OSH: begin
        lo_d = lo_q >> 1;
        hi_d = hi_q >> 1;
      end
      ST_Q_ILO: begin
        raddr = {cur_q, clo_q[CW-1:0]};
        if (clo_q < chi_q && clo_q[0]) begin
          clo_d    = clo_q + (CW+1)'(1);
          acc_sh_d = 1'b0;
        end
      end
      ST_Q_IHI: begin
        chi_d = chi_q - (CW+1)'(1);
        raddr = {cur_q, chi_d[CW-1:0]};
        if (chi_q[0]) acc_sh_d = 1'b1;
        else          chi_d    = chi_q;
      end
      ST_Q_ISH: begin
        clo_d = clo_q >> 1;
        chi_d = chi_q >> 1;
      end
      ST_Q_ACC: begin
        if (rd_s > best_q) best_d = rd_s;
      end
      ST_Q_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign res_o.max_value = best_q;
  assign res_o.empty_res = empty_q;

  always_ff @(posedge clk_i) begin
    if (we) store_q[waddr] <= wdata;
    rdata_q <= store_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q       <= r_d;
    c_q       <= c_d;
    cleaf_q   <= cleaf_d;
    cur_q     <= cur_d;
    rowmode_q <= rowmode_d;
    tmp_q     <= tmp_d;
    best_q    <= best_d;
    empty_q   <= empty_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    clo_q     <= clo_d;
    chi_q     <= chi_d;
    clo0_q    <= clo0_d;
    chi0_q    <= chi0_d;
    ret_hi_q  <= ret_hi_d;
    acc_sh_q  <= acc_sh_d;
  end

endmodule

`default_nettype wire

[rtl/grid_range_max_tree.sv]
// ----------------------------------------------------------------------------
// grid_range_max_tree: two-dimensional range-maximum store
// Cell assignments and rectangle-maximum queries over a signed grid.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 2**(clog2(2*GRID_ROWS) + clog2(2*GRID_COLS))
// entries of its tree memory to zero (16384 at 64 by 64), one entry per cycle,
// before it raises in_ready_o. The memory has one read and one write port,
// and these ports set the pace: an assignment keeps in_ready_o low after
// acceptance while it writes the leaf once and then refreshes every other node
// on its path of L_r * L_c nodes, where L_r = log2(2*GRID_ROWS) and
// L_c = log2(2*GRID_COLS) levels, each refreshed node reading two children and
// writing once. A query walks the row levels and, for each covering row node,
// its column levels, reading one tree node at a time; an empty rectangle goes
// straight to the result without reading the tree. A result sits in an output
// register, so the next transaction is accepted while it waits.
`default_nettype none

module grid_range_max_tree
  import grmt_pkg::*;
#(
  parameter int unsigned GRID_ROWS = GridRowsDef,
  parameter int unsigned GRID_COLS = GridColsDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  logic      res_valid, res_ready;
  out_item_t res;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  grmt_core #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) out_valid_d = 1'b1;
    else if (out_ready_i)       out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_item_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A finished query result holds until the output register takes it.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("core result changed while stalled");

  // An assignment never produces a result right after acceptance.
  a_assign_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.operation == OpAssign |=> !res_valid)
    else $error("assignment produced a result");

  // An empty rectangle always reports zero.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.empty_res |-> res.max_value == 32'sd0)
    else $error("empty result with nonzero maximum");

endmodule

`default_nettype wire
